### rtl/efcw_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the encoder frame check watchdog
// no dependencies

package efcw_pkg;

    localparam int NUM_ENCODERS_DEF = 4;
    localparam int MASK_W           = 4;
    localparam int ANGLE_W          = 14;
    localparam int AGE_W            = 16;
    localparam int COUNT_W          = 32;

    localparam logic [AGE_W-1:0] TIMEOUT_AT_RESET = 16'd5;
    localparam int               WORD_ERR_POS     = 14;

    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_WORD    = 2'd1;
    localparam logic [1:0] CMD_BUS_ERR = 2'd2;

    typedef struct packed {
        logic [MASK_W-1:0]  good_mask;
        logic               in_flight;
        logic               start_pulse;
        logic               select_active;
        logic [COUNT_W-1:0] stall_count;
        logic [COUNT_W-1:0] error_count;
    } status_t;

endpackage

### rtl/efcw_angle_ram.sv
`timescale 1ns / 1ps
// angle store: synchronous memory with registered read, per-entry valid bits
// depends on efcw_pkg

module efcw_angle_ram #(
    parameter int NUM_ENCODERS = efcw_pkg::NUM_ENCODERS_DEF,
    parameter int AW           = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        rd_en,
    input  logic                        wr_en,
    input  logic [AW-1:0]               addr,
    input  logic [efcw_pkg::ANGLE_W-1:0] wr_data,
    output logic [efcw_pkg::ANGLE_W-1:0] rd_angle
);
    import efcw_pkg::*;

    logic [ANGLE_W-1:0]      mem [NUM_ENCODERS];
    logic [NUM_ENCODERS-1:0] entry_vld_reg;
    logic [ANGLE_W-1:0]      rd_data_reg;
    logic [ANGLE_W-1:0]      fwd_data_reg;
    logic                    fwd_hit_reg;
    logic                    rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg  <= mem[addr];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_vld_reg <= '0;
            fwd_hit_reg   <= 1'b0;
            rd_vld_reg    <= 1'b0;
        end else begin
            if (wr_en) begin
                entry_vld_reg[addr] <= 1'b1;
            end
            if (rd_en) begin
                // same-cycle write to the entry being read wins
                fwd_hit_reg <= wr_en;
                rd_vld_reg  <= entry_vld_reg[addr];
            end
        end
    end

    assign rd_angle = fwd_hit_reg ? fwd_data_reg :
                      (rd_vld_reg ? rd_data_reg : '0);

endmodule

### rtl/efcw_ctrl.sv
`timescale 1ns / 1ps
// transfer control: watchdog aging, frame check, masks, counters, timeout register
// depends on efcw_pkg

module efcw_ctrl #(
    parameter int NUM_ENCODERS = efcw_pkg::NUM_ENCODERS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       fire,
    input  logic [1:0]                 cmd,
    input  logic [15:0]                rx_word,
    input  logic [1:0]                 enc_index,
    input  logic                       last_word,
    input  logic                       start_accepted,
    input  logic                       cfg_write,
    input  logic [efcw_pkg::AGE_W-1:0] cfg_data,
    output logic                       in_range,
    output logic                       store_en,
    output efcw_pkg::status_t          status_next
);
    import efcw_pkg::*;

    logic [MASK_W-1:0]  good_mask_reg, good_mask_next;
    logic [MASK_W-1:0]  pending_reg, pending_next;
    logic               busy_reg, busy_next;
    logic               cs_reg, cs_next;
    logic [AGE_W-1:0]   age_reg, age_next;
    logic [COUNT_W-1:0] stalls_reg, stalls_next;
    logic [COUNT_W-1:0] errors_reg, errors_next;
    logic [AGE_W-1:0]   timeout_reg;
    logic               launched;
    logic               word_good;
    logic [AGE_W-1:0]   age_inc;
    logic [MASK_W-1:0]  idx_bit;

    assign in_range  = {30'd0, enc_index} < 32'(NUM_ENCODERS);
    // even parity over the whole frame, error flag clear
    assign word_good = !(^rx_word) && !rx_word[WORD_ERR_POS];
    assign age_inc   = age_reg + 1'b1;
    assign idx_bit   = MASK_W'(1) << enc_index;

    always_comb begin
        good_mask_next = good_mask_reg;
        pending_next   = pending_reg;
        busy_next      = busy_reg;
        cs_next        = cs_reg;
        age_next       = age_reg;
        stalls_next    = stalls_reg;
        errors_next    = errors_reg;
        launched       = 1'b0;
        store_en       = 1'b0;
        unique case (cmd)
            CMD_TICK: begin
                if (busy_reg) begin
                    age_next = age_inc;
                    if (age_inc >= timeout_reg) begin
                        stalls_next    = stalls_reg + 1'b1;
                        busy_next      = 1'b0;
                        cs_next        = 1'b0;
                        age_next       = '0;
                        pending_next   = '0;
                        good_mask_next = '0;
                    end
                end else begin
                    age_next     = '0;
                    pending_next = '0;
                    busy_next    = start_accepted;
                    cs_next      = start_accepted;
                    launched     = start_accepted;
                end
            end
            CMD_WORD: begin
                if (busy_reg) begin
                    if (word_good && in_range) begin
                        store_en     = 1'b1;
                        pending_next = pending_reg | idx_bit;
                    end
                    if (last_word) begin
                        good_mask_next = pending_next;
                        pending_next   = '0;
                        busy_next      = 1'b0;
                        cs_next        = 1'b0;
                        age_next       = '0;
                    end
                end
            end
            CMD_BUS_ERR: begin
                errors_next    = errors_reg + 1'b1;
                busy_next      = 1'b0;
                cs_next        = 1'b0;
                age_next       = '0;
                pending_next   = '0;
                good_mask_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        status_next.good_mask     = good_mask_next;
        status_next.in_flight     = busy_next;
        status_next.start_pulse   = launched;
        status_next.select_active = cs_next;
        status_next.stall_count   = stalls_next;
        status_next.error_count   = errors_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            good_mask_reg <= '0;
            pending_reg   <= '0;
            busy_reg      <= 1'b0;
            cs_reg        <= 1'b0;
            age_reg       <= '0;
            stalls_reg    <= '0;
            errors_reg    <= '0;
            timeout_reg   <= TIMEOUT_AT_RESET;
        end else begin
            if (fire) begin
                good_mask_reg <= good_mask_next;
                pending_reg   <= pending_next;
                busy_reg      <= busy_next;
                cs_reg        <= cs_next;
                age_reg       <= age_next;
                stalls_reg    <= stalls_next;
                errors_reg    <= errors_next;
            end
            if (cfg_write) begin
                timeout_reg <= cfg_data;
            end
        end
    end

    a_select_tracks_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg == cs_reg)
        else $error("chip select out of step with transfer state");

    a_bus_error_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && cmd == CMD_BUS_ERR |=> errors_reg == $past(errors_reg) + 1'b1 && !busy_reg)
        else $error("bus error not counted or transfer not aborted");

    a_store_needs_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        store_en |-> busy_reg && cmd == CMD_WORD && in_range)
        else $error("angle stored outside a transfer");

endmodule

### rtl/encoder_frame_check_watchdog_top.sv
`timescale 1ns / 1ps
// top level of the encoder frame check watchdog
// depends on efcw_pkg, efcw_ctrl, efcw_angle_ram

// Usage
//   s_* channel: one command item per accepted valid/ready handshake
//   (tick or start request, received encoder word, bus error).
//   m_* channel: one status item per command item, in order, showing the
//   state after that command: selected stored angle, valid mask, transfer
//   flags and the stall and bus error counters.
//   cfg_* channel: writes the 16-bit timeout in ticks; write it only while
//   no item is outstanding. cfg_ready is always high.
// Pipeline
//   each item passes the read stage and then the output register: the
//   control update and the angle memory read happen when the item is
//   accepted, and the output register loads from the read stage when it
//   can move. One item per cycle is sustained while m_ready stays high;
//   a write to the entry being read is forwarded into the read data.
// Reset and stall
//   aresetn low clears all control state, the counters, the angle valid
//   bits and restores a timeout of 5 ticks. When m_ready is low a full output
//   register holds and the read stage holds behind it; s_ready drops once both are full.

module encoder_frame_check_watchdog_top #(
    parameter int NUM_ENCODERS = efcw_pkg::NUM_ENCODERS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_cmd,
    input  logic [15:0]                  s_rx_word,
    input  logic [1:0]                   s_enc_index,
    input  logic                         s_last_word,
    input  logic                         s_start_accepted,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [efcw_pkg::ANGLE_W-1:0] m_angle,
    output logic [efcw_pkg::MASK_W-1:0]  m_good_mask,
    output logic                         m_in_flight,
    output logic                         m_start_pulse,
    output logic                         m_select_active,
    output logic [efcw_pkg::COUNT_W-1:0] m_stall_count,
    output logic [efcw_pkg::COUNT_W-1:0] m_error_count,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [efcw_pkg::AGE_W-1:0]   cfg_data
);
    import efcw_pkg::*;

    localparam int AW = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;

    logic               s_fire;
    logic               s1_move;
    logic               in_range;
    logic               store_en;
    status_t            status_next;
    logic [ANGLE_W-1:0] rd_angle;

    logic               s1_valid_reg;
    status_t            s1_status_reg;
    logic               s1_in_range_reg;

    logic               m_valid_reg;
    logic [ANGLE_W-1:0] m_angle_reg;
    status_t            m_status_reg;

    assign cfg_ready = 1'b1;
    assign s1_move   = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !s1_valid_reg || !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;

    efcw_ctrl #(
        .NUM_ENCODERS(NUM_ENCODERS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (s_fire),
        .cmd           (s_cmd),
        .rx_word       (s_rx_word),
        .enc_index     (s_enc_index),
        .last_word     (s_last_word),
        .start_accepted(s_start_accepted),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .in_range      (in_range),
        .store_en      (store_en),
        .status_next   (status_next)
    );

    efcw_angle_ram #(
        .NUM_ENCODERS(NUM_ENCODERS),
        .AW          (AW)
    ) u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_fire && in_range),
        .wr_en   (s_fire && store_en),
        .addr    (AW'(s_enc_index)),
        .wr_data (s_rx_word[ANGLE_W-1:0]),
        .rd_angle(rd_angle)
    );

    // read stage: holds status while the angle read completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_fire) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_move) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_status_reg   <= status_next;
            s1_in_range_reg <= in_range;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_move) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            m_angle_reg  <= s1_in_range_reg ? rd_angle : '0;
            m_status_reg <= s1_status_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_angle         = m_angle_reg;
    assign m_good_mask     = m_status_reg.good_mask;
    assign m_in_flight     = m_status_reg.in_flight;
    assign m_start_pulse   = m_status_reg.start_pulse;
    assign m_select_active = m_status_reg.select_active;
    assign m_stall_count   = m_status_reg.stall_count;
    assign m_error_count   = m_status_reg.error_count;

    a_ready_low_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> s1_valid_reg && m_valid_reg && !m_ready)
        else $error("input stalled with room in the pipeline");

    a_item_reaches_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !m_valid_reg |=> m_valid_reg)
        else $error("read stage item did not advance");

    a_start_implies_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg.start_pulse |-> m_status_reg.in_flight)
        else $error("start reported without a transfer in flight");

endmodule

### verif/efcw_checker.sv
`timescale 1ns / 1ps
// status checker for the encoder frame check watchdog: tracks the transfer
// state from the accepted command items and compares every status item
// depends on efcw_pkg

module efcw_checker #(
    parameter int NUM_ENCODERS = efcw_pkg::NUM_ENCODERS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [1:0]                   s_cmd,
    input  logic [15:0]                  s_rx_word,
    input  logic [1:0]                   s_enc_index,
    input  logic                         s_last_word,
    input  logic                         s_start_accepted,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [efcw_pkg::ANGLE_W-1:0] m_angle,
    input  logic [efcw_pkg::MASK_W-1:0]  m_good_mask,
    input  logic                         m_in_flight,
    input  logic                         m_start_pulse,
    input  logic                         m_select_active,
    input  logic [efcw_pkg::COUNT_W-1:0] m_stall_count,
    input  logic [efcw_pkg::COUNT_W-1:0] m_error_count,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [efcw_pkg::AGE_W-1:0]   cfg_data,
    output int                           fail_count,
    output int                           pending_results
);
    import efcw_pkg::*;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        status_t            status;
    } status_item_t;

    // tracked block state
    logic [ANGLE_W-1:0] angles [MASK_W];
    logic [MASK_W-1:0]  committed_mask;
    logic [MASK_W-1:0]  collecting_mask;
    logic               transfer_busy;
    logic [AGE_W-1:0]   age;
    logic               cs_active;
    logic [COUNT_W-1:0] stall_total;
    logic [COUNT_W-1:0] bus_err_total;
    logic [AGE_W-1:0]   timeout_limit;

    status_item_t expected_status [$];

    initial begin
        fail_count      = 0;
        pending_results = 0;
    end

    task automatic report(input string msg);
        $display("%0t ns: status mismatch, %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    function automatic void drop_transfer();
        cs_active       = 1'b0;
        transfer_busy   = 1'b0;
        age             = '0;
        collecting_mask = '0;
        committed_mask  = '0;
    endfunction

    function automatic status_item_t apply_command(
        input logic [1:0] cmd, input logic [15:0] word, input logic [1:0] idx,
        input logic last, input logic took);
        status_item_t r;
        logic         launched;
        logic         good;
        launched = 1'b0;
        case (cmd)
            CMD_TICK: begin
                if (transfer_busy) begin
                    age = age + 1'b1;
                    if (age >= timeout_limit) begin
                        stall_total = stall_total + 1'b1;
                        drop_transfer();
                    end
                end else begin
                    age             = '0;
                    collecting_mask = '0;
                    transfer_busy   = took;
                    cs_active       = took;
                    launched        = took;
                end
            end
            CMD_WORD: begin
                // words arriving with no transfer in flight are dropped
                if (transfer_busy) begin
                    good = (^word == 1'b0) && !word[WORD_ERR_POS];
                    if (good && idx < NUM_ENCODERS) begin
                        angles[idx]          = word[ANGLE_W-1:0];
                        collecting_mask[idx] = 1'b1;
                    end
                    if (last) begin
                        committed_mask  = collecting_mask;
                        collecting_mask = '0;
                        transfer_busy   = 1'b0;
                        cs_active       = 1'b0;
                        age             = '0;
                    end
                end
            end
            CMD_BUS_ERR: begin
                bus_err_total = bus_err_total + 1'b1;
                drop_transfer();
            end
            default: ;
        endcase
        r.angle                = (idx < NUM_ENCODERS) ? angles[idx] : '0;
        r.status.good_mask     = committed_mask;
        r.status.in_flight     = transfer_busy;
        r.status.start_pulse   = launched;
        r.status.select_active = cs_active;
        r.status.stall_count   = stall_total;
        r.status.error_count   = bus_err_total;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        status_item_t want;
        if (!aresetn) begin
            for (int i = 0; i < MASK_W; i++)
                angles[i] = '0;
            committed_mask  = '0;
            collecting_mask = '0;
            transfer_busy   = 1'b0;
            age             = '0;
            cs_active       = 1'b0;
            stall_total     = '0;
            bus_err_total   = '0;
            timeout_limit   = TIMEOUT_AT_RESET;
            expected_status.delete();
            pending_results <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_status.size() == 0) begin
                    report("status item with none expected");
                end else begin
                    want = expected_status.pop_front();
                    check_field("angle", 32'(m_angle), 32'(want.angle));
                    check_field("good_mask", 32'(m_good_mask),
                                32'(want.status.good_mask));
                    check_field("in_flight", 32'(m_in_flight),
                                32'(want.status.in_flight));
                    check_field("start_pulse", 32'(m_start_pulse),
                                32'(want.status.start_pulse));
                    check_field("select_active", 32'(m_select_active),
                                32'(want.status.select_active));
                    check_field("stall_count", m_stall_count, want.status.stall_count);
                    check_field("error_count", m_error_count, want.status.error_count);
                end
            end
            // an item accepted with a timeout write still sees the old timeout
            if (s_valid && s_ready)
                expected_status.push_back(apply_command(s_cmd, s_rx_word, s_enc_index,
                                                        s_last_word, s_start_accepted));
            if (cfg_valid && cfg_ready)
                timeout_limit = cfg_data;
            pending_results <= expected_status.size();
        end
    end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// top of the encoder frame check watchdog testbench: clock, reset, command
// stimulus, receiver stalls, idle watchdog and verdict
// depends on efcw_pkg, efcw_checker and the encoder_frame_check_watchdog_top rtl

module testbench;
    import efcw_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         IDLE_LIMIT = 5000;
    localparam int         HOLD_CYCLES = 400;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [1:0]          s_cmd = '0;
    logic [15:0]         s_rx_word = '0;
    logic [1:0]          s_enc_index = '0;
    logic                s_last_word = 1'b0;
    logic                s_start_accepted = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [ANGLE_W-1:0]  m_angle;
    logic [MASK_W-1:0]   m_good_mask;
    logic                m_in_flight;
    logic                m_start_pulse;
    logic                m_select_active;
    logic [COUNT_W-1:0]  m_stall_count;
    logic [COUNT_W-1:0]  m_error_count;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [AGE_W-1:0]    cfg_data = '0;

    int fail_count;
    int pending_results;
    int items_sent = 0;
    int burst_left = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int idle_cycles = 0;
    bit offering = 0;
    bit no_gaps = 0;

    encoder_frame_check_watchdog_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_rx_word(s_rx_word),
        .s_enc_index(s_enc_index), .s_last_word(s_last_word),
        .s_start_accepted(s_start_accepted),
        .m_valid(m_valid), .m_ready(m_ready), .m_angle(m_angle),
        .m_good_mask(m_good_mask), .m_in_flight(m_in_flight),
        .m_start_pulse(m_start_pulse), .m_select_active(m_select_active),
        .m_stall_count(m_stall_count), .m_error_count(m_error_count),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    efcw_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_rx_word(s_rx_word),
        .s_enc_index(s_enc_index), .s_last_word(s_last_word),
        .s_start_accepted(s_start_accepted),
        .m_valid(m_valid), .m_ready(m_ready), .m_angle(m_angle),
        .m_good_mask(m_good_mask), .m_in_flight(m_in_flight),
        .m_start_pulse(m_start_pulse), .m_select_active(m_select_active),
        .m_stall_count(m_stall_count), .m_error_count(m_error_count),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_results(pending_results)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ends the run when nothing moves for too long
    initial begin
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // receiver: stall pattern changes every so often, plus requested long holds
    initial begin : receiver
        int rx_mode;
        int rx_left;
        int phase;
        rx_mode = 0;
        rx_left = 0;
        phase   = 0;
        forever begin
            @(posedge aclk);
            phase++;
            if (hold_served != hold_requests) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_served++;
            end else begin
                if (rx_left == 0) begin
                    rx_mode = $urandom_range(0, 3);
                    rx_left = $urandom_range(16, 120);
                end
                rx_left--;
                case (rx_mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (phase % 7 != 3) && (phase % 5 != 1);
                endcase
            end
        end
    end

    function automatic logic [15:0] make_word(input logic [ANGLE_W-1:0] angle,
                                              input logic err, input logic bad_parity);
        logic [15:0] w;
        w = {1'b0, err, angle};
        w[15] = (^w[14:0]) ^ bad_parity;
        return w;
    endfunction

    function automatic logic [15:0] rand_word();
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [1:0] rand_idx();
        return 2'($urandom_range(0, 3));
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic send_item(input logic [1:0] cmd, input logic [15:0] word,
                             input logic [1:0] idx, input logic last, input logic took);
        s_cmd            <= cmd;
        s_rx_word        <= word;
        s_enc_index      <= idx;
        s_last_word      <= last;
        s_start_accepted <= took;
        s_valid          <= 1'b1;
        offering = 1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (cmd != CMD_UNUSED)
            items_sent++;
        if (!no_gaps) begin
            if (burst_left == 0) begin
                s_valid <= 1'b0;
                offering = 0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                burst_left = $urandom_range(1, 40);
            end else begin
                burst_left--;
            end
        end
    endtask

    // stop offering and wait until every status item has come back
    task automatic drain();
        if (offering) begin
            s_valid <= 1'b0;
            offering = 0;
        end
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_timeout(input logic [AGE_W-1:0] value);
        drain();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_noise();
        send_item(rand_idx(), rand_word(), rand_idx(), rand_bit(), rand_bit());
    endtask

    // start, a few words with aging ticks and faults mixed in; the final word usually closes the transfer
    task automatic run_transfer();
        int          n_words;
        int          pick;
        logic [1:0]  idx;
        logic        close;
        logic [15:0] word;
        if ($urandom_range(0, 9) == 0)
            send_item(CMD_TICK, rand_word(), rand_idx(), rand_bit(), 1'b0);
        send_item(CMD_TICK, rand_word(), rand_idx(), rand_bit(), 1'b1);
        n_words = $urandom_range(1, 5);
        close   = ($urandom_range(0, 9) != 0);
        for (int k = 0; k < n_words; k++) begin
            while ($urandom_range(0, 99) < 15)
                send_item(CMD_TICK, rand_word(), rand_idx(), rand_bit(), rand_bit());
            pick = $urandom_range(0, 99);
            if (pick < 3)
                send_item(CMD_BUS_ERR, rand_word(), rand_idx(), rand_bit(), rand_bit());
            else if (pick < 6)
                send_item(CMD_UNUSED, rand_word(), rand_idx(), rand_bit(), rand_bit());
            idx  = ($urandom_range(0, 3) == 0) ? rand_idx() : 2'(k % 4);
            word = make_word(14'($urandom_range(0, 16383)), $urandom_range(0, 15) == 0,
                             $urandom_range(0, 11) == 0);
            send_item(CMD_WORD, word, idx, close && (k == n_words - 1), rand_bit());
        end
    endtask

    task automatic run_random(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) begin
            if ($urandom_range(0, 4) == 0)
                send_noise();
            else
                run_transfer();
        end
    endtask

    initial begin : stimulus
        logic [AGE_W-1:0] settings [6];
        settings[0] = 16'd1;
        settings[1] = 16'd0;
        settings[2] = 16'd3;
        settings[3] = 16'hFFFF;
        settings[4] = 16'($urandom_range(2, 20));
        settings[5] = TIMEOUT_AT_RESET;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        burst_left = $urandom_range(1, 40);

        // directed: idle corner cases first, at the reset timeout
        send_item(CMD_UNUSED, 16'hFFFF, 2'd3, 1'b1, 1'b1);
        send_item(CMD_WORD, make_word(14'h1234, 1'b0, 1'b0), 2'd0, 1'b1, 1'b0);
        send_item(CMD_BUS_ERR, 16'h0000, 2'd0, 1'b0, 1'b0);
        send_item(CMD_TICK, 16'h0000, 2'd0, 1'b0, 1'b0);
        send_item(CMD_TICK, 16'hFFFF, 2'd3, 1'b1, 1'b1);
        send_item(CMD_WORD, make_word(14'h3FFF, 1'b0, 1'b0), 2'd0, 1'b0, 1'b0);
        send_item(CMD_WORD, 16'h0000, 2'd1, 1'b0, 1'b0);
        send_item(CMD_WORD, make_word(14'h2AAA, 1'b0, 1'b1), 2'd2, 1'b0, 1'b0);
        send_item(CMD_WORD, 16'hFFFF, 2'd3, 1'b0, 1'b0);
        send_item(CMD_TICK, 16'h0000, 2'd1, 1'b0, 1'b1);
        send_item(CMD_WORD, make_word(14'h1555, 1'b0, 1'b0), 2'd3, 1'b1, 1'b0);
        send_item(CMD_UNUSED, 16'h0000, 2'd2, 1'b0, 1'b0);
        // stalled transfer: the reset timeout of five ticks runs out
        send_item(CMD_TICK, 16'h0000, 2'd0, 1'b0, 1'b1);
        repeat (5) send_item(CMD_TICK, 16'h0000, 2'd1, 1'b0, 1'b0);
        // bus error in the middle of a transfer
        send_item(CMD_TICK, 16'h0000, 2'd0, 1'b0, 1'b1);
        send_item(CMD_WORD, make_word(14'h0001, 1'b0, 1'b0), 2'd2, 1'b0, 1'b0);
        send_item(CMD_BUS_ERR, 16'hFFFF, 2'd2, 1'b1, 1'b1);
        // last word that fails its check still commits
        send_item(CMD_TICK, 16'h0000, 2'd0, 1'b0, 1'b1);
        send_item(CMD_WORD, make_word(14'h0F0F, 1'b1, 1'b0), 2'd1, 1'b1, 1'b0);

        run_random(150);

        // long receiver hold while items keep coming, so the input backs up
        hold_requests++;
        no_gaps = 1;
        run_random(60);
        no_gaps = 0;

        foreach (settings[i]) begin
            write_timeout(settings[i]);
            run_random(170);
        end

        drain();
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
